@@ hdl/qnll_pkg.sv @@
`timescale 1ns / 1ps

package qnll_pkg;

   // Widths of the result fields, fixed by the port list.
   localparam int LINE_FIELD_BITS   = 24;
   localparam int COLUMN_FIELD_BITS = 16;
   localparam logic [LINE_FIELD_BITS-1:0]   LINE_FIELD_MAX   = '1;
   localparam logic [COLUMN_FIELD_BITS-1:0] COLUMN_FIELD_MAX = '1;

   // Default counter widths.
   localparam int LINE_BITS_DEFAULT   = 24;
   localparam int COLUMN_BITS_DEFAULT = 16;

   // Result queue depth; it must hold at least two entries.
   localparam int RSP_DEPTH = 4;

   // Input action codes.
   localparam logic ACTION_DATA = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   // Characters the lexer reacts to.
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_PLAIN  = 2'd1,
      MODE_QUOTED = 2'd2,
      MODE_ESCAPE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_BYTE         = 3'd0,
      KIND_END          = 3'd1,
      KIND_UNTERMINATED = 3'd2,
      KIND_BAD_ESCAPE   = 3'd3,
      KIND_FINISHED     = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic [7:0]                   name_byte;
      logic [LINE_FIELD_BITS-1:0]   line_number;
      logic [COLUMN_FIELD_BITS-1:0] column_number;
      logic                         last;
   } rsp_item_type;

   // Up to two results produced by one input transfer.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

endpackage

@@ hdl/qnll_core.sv @@
`timescale 1ns / 1ps

module qnll_core #(
   parameter int LINE_BITS   = qnll_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = qnll_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   action,
   input  logic [7:0]             byte_value,
   output qnll_pkg::rsp_push_type push
);
   import qnll_pkg::*;

   localparam int LINE_W = (LINE_BITS > LINE_FIELD_BITS) ? LINE_BITS : LINE_FIELD_BITS;
   localparam int COL_W  = (COLUMN_BITS > COLUMN_FIELD_BITS) ? COLUMN_BITS
                                                              : COLUMN_FIELD_BITS;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

   mode_type                mode_ff, mode_in;
   logic [LINE_BITS-1:0]    line_ff, line_in;
   logic [COLUMN_BITS-1:0]  column_ff, column_in;

   logic [LINE_BITS-1:0]         line_inc;
   logic [COLUMN_BITS-1:0]       column_inc;
   logic [LINE_W-1:0]            line_wide;
   logic [LINE_FIELD_BITS-1:0]   line_field;
   logic [COLUMN_FIELD_BITS-1:0] col_here;
   logic [COLUMN_FIELD_BITS-1:0] col_next;
   logic                         is_sep;

   // Clamp a column counter value to the width of the result field.
   function automatic logic [COLUMN_FIELD_BITS-1:0] clamp_col(
      input logic [COLUMN_BITS-1:0] value
   );
      logic [COL_W-1:0] wide;
      wide = COL_W'(value);
      if (wide > COL_W'(COLUMN_FIELD_MAX)) begin
         return COLUMN_FIELD_MAX;
      end
      return wide[COLUMN_FIELD_BITS-1:0];
   endfunction

   // Saturating increments and the clamped field values that the results draw on.
   assign line_inc   = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
   assign column_inc = (column_ff == COL_MAX) ? column_ff : column_ff + 1'b1;
   assign line_wide  = LINE_W'(line_ff);
   assign line_field = (line_wide > LINE_W'(LINE_FIELD_MAX)) ? LINE_FIELD_MAX
                                                             : line_wide[LINE_FIELD_BITS-1:0];
   assign col_here   = clamp_col(column_ff);
   assign col_next   = clamp_col(column_inc);
   assign is_sep     = (byte_value == CHAR_SPACE) || (byte_value == CHAR_TAB) ||
                       (byte_value == CHAR_NEWLINE);

   // Next state and results for the item presented this cycle.
   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      column_in = column_ff;
      push      = '0;
      push.item0.line_number = line_field;
      push.item1.line_number = line_field;
      push.item0.kind = KIND_BYTE;
      push.item1.kind = KIND_FINISHED;

      if (action == ACTION_END) begin
         // End of stream: report and return to the reset state.
         push.item0.column_number = col_next;
         push.item1.column_number = col_next;
         push.count = 2'd1;
         case (mode_ff)
            MODE_QUOTED: begin
               push.item0.kind = KIND_UNTERMINATED;
            end
            MODE_ESCAPE: begin
               push.item0.kind = KIND_BAD_ESCAPE;
               push.item0.column_number = col_here;
            end
            MODE_PLAIN: begin
               push.item0.kind = KIND_END;
               push.count = 2'd2;
            end
            default: begin
               push.item0.kind = KIND_FINISHED;
            end
         endcase
         mode_in   = MODE_IDLE;
         line_in   = LINE_BITS'(1);
         column_in = '0;
      end else if (mode_ff == MODE_ESCAPE) begin
         // Only a quote or a backslash may follow the escape character.
         if ((byte_value != CHAR_QUOTE) && (byte_value != CHAR_BACKSLASH)) begin
            push.count = 2'd1;
            push.item0.kind = KIND_BAD_ESCAPE;
            push.item0.column_number = col_here;
            mode_in   = MODE_IDLE;
            line_in   = LINE_BITS'(1);
            column_in = '0;
         end else begin
            push.count = 2'd1;
            push.item0.kind = KIND_BYTE;
            push.item0.name_byte = byte_value;
            push.item0.column_number = col_next;
            mode_in   = MODE_QUOTED;
            column_in = column_inc;
         end
      end else begin
         column_in = column_inc;
         push.item0.column_number = col_next;
         case (mode_ff)
            MODE_IDLE: begin
               if (is_sep) begin
                  mode_in = MODE_IDLE;
               end else if (byte_value == CHAR_QUOTE) begin
                  mode_in = MODE_QUOTED;
               end else begin
                  mode_in = MODE_PLAIN;
                  push.count = 2'd1;
                  push.item0.name_byte = byte_value;
               end
            end
            MODE_PLAIN: begin
               push.count = 2'd1;
               if (is_sep) begin
                  push.item0.kind = KIND_END;
                  mode_in = MODE_IDLE;
               end else begin
                  push.item0.name_byte = byte_value;
               end
            end
            default: begin
               if (byte_value == CHAR_QUOTE) begin
                  push.count = 2'd1;
                  push.item0.kind = KIND_END;
                  mode_in = MODE_IDLE;
               end else if (byte_value == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  push.count = 2'd1;
                  push.item0.name_byte = byte_value;
               end
            end
         endcase
         // A newline starts the next line at column zero.
         if (byte_value == CHAR_NEWLINE) begin
            line_in   = line_inc;
            column_in = '0;
         end
      end

      push.item0.last = (push.count == 2'd1);
      push.item1.last = 1'b1;
   end

   // Lexer state advances only on a step.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= LINE_BITS'(1);
         column_ff <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         column_ff <= column_in;
      end
   end

endmodule

@@ hdl/qnll_rsp_fifo.sv @@
`timescale 1ns / 1ps

module qnll_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_en,
   input  qnll_pkg::rsp_push_type push,
   output logic                   room,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output qnll_pkg::rsp_item_type head
);
   import qnll_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_item_type     entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;
   logic             pop;
   logic [1:0]       push_count;

   assign rsp_valid  = (count_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   assign push_count = push_en ? push.count : 2'd0;
   assign head       = entry_ff[rd_ptr_ff];
   assign wr_next    = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;

   // Two free entries are needed after this cycle's transfer out.
   assign room = (count_ff <= CNT_W'(RSP_DEPTH - 2)) ||
                 (pop && (count_ff <= CNT_W'(RSP_DEPTH - 1)));

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_count == 2'd1) begin
         wr_ptr_in = wr_next;
      end else if (push_count == 2'd2) begin
         wr_ptr_in = (wr_next == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_next + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.item0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push.item1;
      end
   end

endmodule

@@ hdl/quoted_name_list_lexer_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_action, req_byte_value
// rsp_      out        rsp_valid / rsp_ready  rsp_kind, rsp_name_byte, rsp_line_number,
//                                             rsp_column_number, rsp_last
//
// One input byte is taken per cycle while req_ready is high. A transfer lands in the input
// register and is lexed once the result queue has room for two results; results leave
// the queue one per cycle while rsp_ready is high. Synchronous reset empties both
// stages and puts the lexer in idle at line one, column zero. A stall on rsp_ holds
// req_ready low only while an item waits in the input register and the queue holds
// three results with none leaving, or is full.

module quoted_name_list_lexer_unit #(
   parameter int LINE_BITS   = qnll_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = qnll_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_action,
   input  logic [7:0]                               req_byte_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [2:0]                               rsp_kind,
   output logic [7:0]                               rsp_name_byte,
   output logic [qnll_pkg::LINE_FIELD_BITS-1:0]     rsp_line_number,
   output logic [qnll_pkg::COLUMN_FIELD_BITS-1:0]   rsp_column_number,
   output logic                                     rsp_last
);
   import qnll_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic         in_action_ff;
   logic [7:0]   in_byte_ff;
   logic         req_fire;
   logic         step;
   logic         room;
   rsp_push_type push;
   rsp_item_type head;

   // Input register: a held item steps when the queue can take its results.
   assign step      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || step;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_byte_value;
      end
   end

   qnll_core #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .action     (in_action_ff),
      .byte_value (in_byte_ff),
      .push       (push)
   );

   qnll_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (step),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   // Result port fields from the queue head.
   assign rsp_kind          = head.kind;
   assign rsp_name_byte     = head.name_byte;
   assign rsp_line_number   = head.line_number;
   assign rsp_column_number = head.column_number;
   assign rsp_last          = head.last;

`ifndef NO_ASSERTIONS
   // End of input always reports at least one result.
   assert property (@(posedge clock) disable iff (reset)
      (step && (in_action_ff == ACTION_END)) |-> (push.count != 2'd0))
      else $error("end of input stepped without a result");

   // A pair of results is only ever a name end followed by stream finished.
   assert property (@(posedge clock) disable iff (reset)
      (step && (push.count == 2'd2)) |->
         ((push.item0.kind == KIND_END) && (push.item1.kind == KIND_FINISHED) &&
          !push.item0.last && push.item1.last))
      else $error("unexpected result pair");

   // The input side stalls only while an item is held in the input register.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff)
      else $error("input stalled with an empty input register");
`endif

endmodule
